// ----- hdl/esd_pkg.sv -----
// Shared types and constants for the escape sequence decoder.
package esd_pkg;

   localparam int MAX_HEX_DIGITS_DEFAULT = 16;
   localparam int CMD_QUEUE_DEPTH_DEFAULT = 4;
   localparam int HEX_BYTES_W = 4;
   localparam int UNIT_W = 4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] decoded_byte;
      logic       final_out;
   } rsp_type;

   // One decoded step: hex bytes (LSB first), then up to two literal bytes.
   typedef struct packed {
      logic [HEX_BYTES_W-1:0] hex_bytes;
      logic [63:0]            hex_value;
      logic [1:0]             lit_cnt;
      logic [1:0][7:0]        lits;
      logic                   last;
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_TEXT = 3'b001,
      MODE_ESC  = 3'b010,
      MODE_HEX  = 3'b100
   } mode_type;

endpackage

// ----- hdl/escape_sequence_decoder.sv -----
// Escape sequence decoder top level: front end, command queue, byte emitter.
// Path: an accepted beat's command is written into the command queue, then its bytes are registered onto rsp.
// Throughput: one text beat per cycle in; one decoded byte per cycle out unless rsp_stall.
// A hex flush of 1, 2, 4 or 8 bytes plus any literal occupies the emitter until each byte is sent;
// req_stall rises only while the command queue (QUEUE_DEPTH entries) is full.
// Reset is synchronous, active high: clears mode, hex state, queue and output valid.
module escape_sequence_decoder #(
   parameter int MAX_HEX_DIGITS = esd_pkg::MAX_HEX_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH    = esd_pkg::CMD_QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  esd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output esd_pkg::rsp_type rsp_data
);

   logic             q_push, q_full, q_pop, q_empty;
   esd_pkg::cmd_type q_cmd, head_cmd;

   esd_front #(
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   esd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   esd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/esd_front.sv -----
// Front end: accepts text beats, tracks escape state, queues decode commands.
module esd_front #(
   parameter int MAX_HEX_DIGITS = esd_pkg::MAX_HEX_DIGITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  esd_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output esd_pkg::cmd_type q_cmd
);

   localparam int ACC_W = 4 * MAX_HEX_DIGITS;
   localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 1);

   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_UP_A      = 8'h41;
   localparam logic [7:0] CHAR_UP_F      = 8'h46;
   localparam logic [7:0] CHAR_LO_A      = 8'h61;
   localparam logic [7:0] CHAR_LO_B      = 8'h62;
   localparam logic [7:0] CHAR_LO_F      = 8'h66;
   localparam logic [7:0] CHAR_LO_N      = 8'h6E;
   localparam logic [7:0] CHAR_LO_R      = 8'h72;
   localparam logic [7:0] CHAR_LO_T      = 8'h74;
   localparam logic [7:0] CHAR_LO_V      = 8'h76;
   localparam logic [7:0] CHAR_LO_X      = 8'h78;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;

   esd_pkg::mode_type mode_ff, mode_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              accept;
   logic [7:0]        ch;
   logic              last;
   logic              is_dec, is_alpha, is_hex;
   logic [3:0]        digit;
   logic [ACC_W-1:0]  acc_next;
   logic [CNT_W-1:0]  cnt_next;
   logic              do_flush, do_plain;
   logic [CNT_W-1:0]  flush_cnt;
   logic [ACC_W-1:0]  flush_acc;
   logic [4:0]        flush_cnt5;
   esd_pkg::cmd_type  cmd;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign ch        = req_data.text_byte;
   assign last      = req_data.end_of_text;

   assign is_dec   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign is_alpha = ((ch >= CHAR_UP_A) && (ch <= CHAR_UP_F)) ||
                     ((ch >= CHAR_LO_A) && (ch <= CHAR_LO_F));
   assign is_hex   = is_dec || is_alpha;
   assign digit    = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
   assign acc_next = {acc_ff[ACC_W-5:0], digit};
   assign cnt_next = cnt_ff + CNT_W'(1);

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      do_flush  = 1'b0;
      do_plain  = 1'b0;
      flush_cnt = cnt_ff;
      flush_acc = acc_ff;
      flush_cnt5 = '0;
      cmd       = '0;

      if (accept) begin
         case (mode_ff)
            esd_pkg::MODE_ESC: begin
               mode_in = esd_pkg::MODE_TEXT;
               cmd.lit_cnt = 2'd1;
               case (ch)
                  CHAR_ZERO:      cmd.lits[0] = 8'h00;
                  CHAR_LO_A:      cmd.lits[0] = 8'h07;
                  CHAR_LO_B:      cmd.lits[0] = 8'h08;
                  CHAR_LO_F:      cmd.lits[0] = 8'h0C;
                  CHAR_LO_N:      cmd.lits[0] = 8'h0A;
                  CHAR_LO_R:      cmd.lits[0] = 8'h0D;
                  CHAR_LO_T:      cmd.lits[0] = 8'h09;
                  CHAR_LO_V:      cmd.lits[0] = 8'h0B;
                  CHAR_BACKSLASH,
                  CHAR_QUOTE,
                  CHAR_DQUOTE,
                  CHAR_QUESTION:  cmd.lits[0] = ch;
                  CHAR_LO_X: begin
                     acc_in = '0;
                     cnt_in = '0;
                     if (last) begin
                        cmd.lits[0] = CHAR_LO_X;
                     end else begin
                        cmd.lit_cnt = 2'd0;
                        mode_in = esd_pkg::MODE_HEX;
                     end
                  end
                  default: begin
                     cmd.lit_cnt = 2'd2;
                     cmd.lits[0] = CHAR_BACKSLASH;
                     cmd.lits[1] = ch;
                  end
               endcase
            end
            esd_pkg::MODE_HEX: begin
               if (is_hex) begin
                  acc_in = acc_next;
                  cnt_in = cnt_next;
                  if ((5'(cnt_next) >= 5'(MAX_HEX_DIGITS)) || last) begin
                     do_flush  = 1'b1;
                     flush_cnt = cnt_next;
                     flush_acc = acc_next;
                  end
               end else begin
                  do_flush = 1'b1;
                  do_plain = 1'b1;
               end
            end
            default: do_plain = 1'b1;
         endcase

         flush_cnt5 = 5'(flush_cnt);
         if (do_flush) begin
            acc_in  = '0;
            cnt_in  = '0;
            mode_in = esd_pkg::MODE_TEXT;
            if (flush_cnt == '0) begin
               cmd.lits[cmd.lit_cnt[0]] = CHAR_LO_X;
               cmd.lit_cnt = cmd.lit_cnt + 2'd1;
            end else begin
               cmd.hex_value = 64'(flush_acc);
               if (flush_cnt5 <= 5'd2) begin
                  cmd.hex_bytes = 4'd1;
               end else if (flush_cnt5 <= 5'd4) begin
                  cmd.hex_bytes = 4'd2;
               end else if (flush_cnt5 <= 5'd8) begin
                  cmd.hex_bytes = 4'd4;
               end else begin
                  cmd.hex_bytes = 4'd8;
               end
            end
         end

         if (do_plain) begin
            if ((ch == CHAR_BACKSLASH) && !last) begin
               mode_in = esd_pkg::MODE_ESC;
            end else begin
               cmd.lits[cmd.lit_cnt[0]] = ch;
               cmd.lit_cnt = cmd.lit_cnt + 2'd1;
            end
         end

         if (last) begin
            cmd.last = 1'b1;
            mode_in  = esd_pkg::MODE_TEXT;
            acc_in   = '0;
            cnt_in   = '0;
         end
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && ((cmd.lit_cnt != 2'd0) || (cmd.hex_bytes != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= esd_pkg::MODE_TEXT;
         acc_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> ((mode_ff == esd_pkg::MODE_TEXT) && (cnt_ff == '0)))
      else $error("state not cleared after end of text");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      5'(cnt_ff) < 5'(MAX_HEX_DIGITS))
      else $error("hex digit count reached limit without flush");

   a_cnt_only_hex: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != esd_pkg::MODE_HEX) |-> (cnt_ff == '0))
      else $error("hex digit count held outside hex mode");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |-> q_push)
      else $error("end of text produced no command");
`endif

endmodule

// ----- hdl/esd_queue.sv -----
// Command queue between the front end and the byte emitter.
module esd_queue #(
   parameter int DEPTH = esd_pkg::CMD_QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  esd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output esd_pkg::cmd_type head_cmd,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   esd_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_ff + PTR_W'(1));
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_ff + PTR_W'(1));
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/esd_back.sv -----
// Back end: walks each queued command and emits one decoded byte per beat.
module esd_back (
   input  logic             clock,
   input  logic             reset,
   input  esd_pkg::cmd_type head_cmd,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output esd_pkg::rsp_type rsp_data
);

   logic [esd_pkg::UNIT_W-1:0] pos_ff, pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   esd_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                       load;
   logic [esd_pkg::UNIT_W-1:0] total;
   logic [esd_pkg::UNIT_W-1:0] lit_idx;
   logic                       last_unit;
   logic [7:0]                 cur_byte;

   assign total     = esd_pkg::UNIT_W'(head_cmd.hex_bytes) + esd_pkg::UNIT_W'(head_cmd.lit_cnt);
   assign last_unit = ((pos_ff + esd_pkg::UNIT_W'(1)) == total);
   assign lit_idx   = pos_ff - esd_pkg::UNIT_W'(head_cmd.hex_bytes);
   assign cur_byte  = (pos_ff < esd_pkg::UNIT_W'(head_cmd.hex_bytes)) ?
                      head_cmd.hex_value[{pos_ff[2:0], 3'b000} +: 8] :
                      head_cmd.lits[lit_idx[0]];

   assign load  = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = load && last_unit;

   always_comb begin
      pos_in       = pos_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.decoded_byte = cur_byte;
         rsp_data_in.final_out    = head_cmd.last && last_unit;
         pos_in                   = last_unit ? '0 : (pos_ff + esd_pkg::UNIT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_pos_needs_head: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> !q_empty)
      else $error("command position held with no queued command");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (pos_ff < total))
      else $error("command position beyond its byte count");

   a_no_empty_cmd: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (total != '0))
      else $error("queued command carries no bytes");
`endif

endmodule
